@@ rtl/imhtq_pkg.sv @@
// ----------------------------------------------------------------------------
// imhtq_pkg
// Shared constants and types for the indexed min-heap timer queue.
// ----------------------------------------------------------------------------
package imhtq_pkg;

    localparam int HEAP_DEPTH   = 1024;
    localparam int HANDLE_COUNT = 2048;
    localparam int KEY_WIDTH    = 32;

    // A position runs 0..HEAP_DEPTH, 1-based, 0 meaning absent.
    localparam int POS_W    = $clog2(HEAP_DEPTH + 1);
    localparam int HANDLE_W = 11;
    localparam int HIDX_W   = $clog2(HANDLE_COUNT);
    localparam int IN_KEY_W = 32;
    localparam int COUNT_W  = 11;

    typedef enum logic [1:0] {
        ACT_INSERT  = 2'd0,
        ACT_EXTRACT = 2'd1,
        ACT_DELETE  = 2'd2,
        ACT_DELAY   = 2'd3
    } t_action;

    typedef enum logic [1:0] {
        ST_OK     = 2'd0,
        ST_EMPTY  = 2'd1,
        ST_FULL   = 2'd2,
        ST_HANDLE = 2'd3
    } t_status;

    typedef struct packed {
        logic [1:0]            action;
        logic [IN_KEY_W-1:0]   key;
        logic [HANDLE_W-1:0]   handle;
    } t_req;

    typedef struct packed {
        logic [1:0]            status;
        logic [HANDLE_W-1:0]   out_handle;
        logic [IN_KEY_W-1:0]   out_key;
        logic [COUNT_W-1:0]    entry_total;
    } t_rsp;

    // Key a is later than key b by wrap-aware signed difference.
    function automatic logic later(input logic [KEY_WIDTH-1:0] a,
                                   input logic [KEY_WIDTH-1:0] b);
        logic [KEY_WIDTH-1:0] d;
        d = a - b;
        return (d != '0) && !d[KEY_WIDTH-1];
    endfunction

endpackage

@@ rtl/imhtq_if.sv @@
// ----------------------------------------------------------------------------
// imhtq_req_if / imhtq_rsp_if
// Valid/ready channels carrying the request and response transactions.
// ----------------------------------------------------------------------------
interface imhtq_req_if;
    logic            valid;
    logic            ready;
    imhtq_pkg::t_req payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

interface imhtq_rsp_if;
    logic            valid;
    logic            ready;
    imhtq_pkg::t_rsp payload;
    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);
endinterface

@@ rtl/indexed_min_heap_timer_queue.sv @@
// ----------------------------------------------------------------------------
// indexed_min_heap_timer_queue
// Binary min-heap of (key, handle) entries with a handle-to-position table.
// ----------------------------------------------------------------------------
// One transaction at a time. A request is taken whenever the block is idle; a
// finished response waits in the output register, and the next request may be
// taken and worked on while it waits (it then holds in its last step until the
// register drains). The heap entries live in one synchronous memory (key and
// handle side by side) and the position table in a second. An error response
// is returned without touching the heap; an insert sifts the new entry up; a
// delay sifts the entry down; an extract or delete moves the last entry into
// the hole and sifts it up, then down (unless the last entry is the one removed).
// After reset a clearing pass walks the position table, one entry a cycle, and
// no request is taken until all HANDLE_COUNT (2048) entries are cleared.
// ----------------------------------------------------------------------------
module indexed_min_heap_timer_queue (
    input  logic i_clk,
    input  logic i_rst_n,
    imhtq_req_if.sink   i_req,
    imhtq_rsp_if.source o_rsp
);

    localparam int KW = imhtq_pkg::KEY_WIDTH;
    localparam int PW = imhtq_pkg::POS_W;
    localparam int HW = imhtq_pkg::HANDLE_W;
    localparam int XW = imhtq_pkg::HIDX_W;
    localparam int CW = imhtq_pkg::COUNT_W;

    typedef struct packed {
        logic [KW-1:0] key;
        logic [HW-1:0] handle;
    } t_ent;

    typedef enum logic [4:0] {
        S_CLEAR, S_IDLE, S_FIND, S_FCHK,
        S_REMOVE, S_REMOVEW,
        S_UP, S_UPCMP, S_REREAD, S_REREADW,
        S_DN, S_DNL, S_DNR, S_DNCMP,
        S_PUT, S_DONE
    } t_state;

    // Memories: heap entries at positions 1..HEAP_DEPTH, and positions by handle.
    t_ent          heap_mem [imhtq_pkg::HEAP_DEPTH+1];
    logic [PW-1:0] pos_mem  [imhtq_pkg::HANDLE_COUNT];

    // Heap port.
    logic          hp_we;
    logic [PW-1:0] hp_addr;
    t_ent          hp_wdata;
    t_ent          r_hp_rdata;
    // Position port.
    logic          pt_we;
    logic [XW-1:0] pt_addr;
    logic [PW-1:0] pt_wdata;
    logic [PW-1:0] r_pt_rdata;

    always_ff @(posedge i_clk) begin
        if (hp_we) begin
            heap_mem[hp_addr] <= hp_wdata;
        end
        r_hp_rdata <= heap_mem[hp_addr];
    end

    always_ff @(posedge i_clk) begin
        if (pt_we) begin
            pos_mem[pt_addr] <= pt_wdata;
        end
        r_pt_rdata <= pos_mem[pt_addr];
    end

    t_state          r_state;
    logic [XW:0]     r_clr;
    logic [PW-1:0]   r_count;
    imhtq_pkg::t_req r_req;
    t_ent            r_ent;      // entry being sifted
    t_ent            r_lch;      // removed entry, or the earlier child
    logic [PW-1:0]   r_pos;      // current hole position
    logic [PW-1:0]   r_start;    // position where a removal refills the hole
    logic [PW-1:0]   r_cpos;     // position of the earlier child
    logic            r_dn;       // sift down from r_start once sift up is done
    imhtq_pkg::t_rsp r_res;      // response under construction
    logic            r_rsp_v;
    imhtq_pkg::t_rsp r_rsp;

    wire req_fire = i_req.valid && i_req.ready;
    assign i_req.ready = (r_state == S_IDLE);
    assign o_rsp.valid = r_rsp_v;
    assign o_rsp.payload = r_rsp;

    wire [PW:0]   w_lc         = {r_pos, 1'b0};
    wire [PW-1:0] w_par        = r_pos >> 1;
    wire          w_no_child   = w_lc > {1'b0, r_count};
    wire          w_has_right  = w_lc < {1'b0, r_count};
    wire [KW-1:0] w_dkey       = r_hp_rdata.key + r_req.key[KW-1:0];
    wire          w_found      = (r_pos != '0) && (r_pos <= r_count) &&
                                 (r_hp_rdata.handle == r_req.handle);
    wire          w_up_move    = imhtq_pkg::later(r_hp_rdata.key, r_ent.key);
    wire          w_dn_move    = imhtq_pkg::later(r_ent.key, r_lch.key);
    wire          w_pick_right = w_has_right &&
                                 imhtq_pkg::later(r_lch.key, r_hp_rdata.key);
    wire          w_rsp_fire   = o_rsp.valid && o_rsp.ready;
    wire          w_rsp_load   = (r_state == S_DONE) && (!r_rsp_v || w_rsp_fire);

    // Memory addressing for each state.
    always_comb begin
        hp_we    = 1'b0;
        hp_addr  = r_pos;
        hp_wdata = r_ent;
        pt_we    = 1'b0;
        pt_addr  = r_ent.handle[XW-1:0];
        pt_wdata = r_pos;
        unique case (r_state)
            S_CLEAR: begin
                pt_we    = 1'b1;
                pt_addr  = r_clr[XW-1:0];
                pt_wdata = '0;
            end
            S_IDLE: begin
                pt_addr = i_req.payload.handle[XW-1:0];
            end
            S_FIND: begin
                // Extract reads the root; the others read where the handle sits.
                hp_addr = (r_req.action == imhtq_pkg::ACT_EXTRACT) ? PW'(1) : r_pt_rdata;
            end
            S_REMOVE: begin
                // Drop the removed handle and fetch the last entry.
                hp_addr  = r_count;
                pt_we    = 1'b1;
                pt_addr  = r_lch.handle[XW-1:0];
                pt_wdata = '0;
            end
            S_UP: begin
                hp_addr = w_par;
            end
            S_UPCMP: begin
                // Move the later parent down into the hole.
                if (w_up_move) begin
                    hp_we    = 1'b1;
                    hp_wdata = r_hp_rdata;
                    pt_we    = 1'b1;
                    pt_addr  = r_hp_rdata.handle[XW-1:0];
                end
            end
            S_REREAD: begin
                hp_addr = r_start;
            end
            S_DN: begin
                if (!w_no_child) begin
                    hp_addr = w_lc[PW-1:0];
                end
            end
            S_DNL: begin
                hp_addr = w_has_right ? (w_lc[PW-1:0] | PW'(1)) : w_lc[PW-1:0];
            end
            S_DNCMP: begin
                // Move the earlier child up into the hole.
                if (w_dn_move) begin
                    hp_we    = 1'b1;
                    hp_wdata = r_lch;
                    pt_we    = 1'b1;
                    pt_addr  = r_lch.handle[XW-1:0];
                end
            end
            S_PUT: begin
                hp_we = 1'b1;
                pt_we = 1'b1;
            end
            default: begin
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_clr   <= '0;
            r_count <= '0;
            r_dn    <= 1'b0;
            r_rsp_v <= 1'b0;
        end else begin
            r_rsp_v <= w_rsp_load || (r_rsp_v && !w_rsp_fire);
            unique case (r_state)
                S_CLEAR: begin
                    r_clr <= r_clr + 1'b1;
                    if (r_clr == (XW+1)'(imhtq_pkg::HANDLE_COUNT - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    if (req_fire) begin
                        r_req             <= i_req.payload;
                        r_res.status      <= imhtq_pkg::ST_OK;
                        r_res.out_handle  <= i_req.payload.handle;
                        r_res.out_key     <= '0;
                        r_res.entry_total <= CW'(r_count);
                        r_dn              <= 1'b0;
                        r_state           <= S_FIND;
                    end
                end
                S_FIND: begin
                    r_pos   <= (r_req.action == imhtq_pkg::ACT_EXTRACT) ? PW'(1) : r_pt_rdata;
                    r_state <= S_FCHK;
                end
                S_FCHK: begin
                    priority if (r_req.action == imhtq_pkg::ACT_INSERT) begin
                        if (r_count == PW'(imhtq_pkg::HEAP_DEPTH)) begin
                            r_res.status <= imhtq_pkg::ST_FULL;
                            r_state      <= S_DONE;
                        end else if (w_found) begin
                            r_res.status <= imhtq_pkg::ST_HANDLE;
                            r_state      <= S_DONE;
                        end else begin
                            r_count           <= r_count + 1'b1;
                            r_res.entry_total <= CW'(r_count + 1'b1);
                            r_res.out_key     <= r_req.key;
                            r_ent             <= '{key: r_req.key[KW-1:0],
                                                   handle: r_req.handle};
                            r_pos             <= r_count + 1'b1;
                            r_state           <= S_UP;
                        end
                    end else if (r_count == '0) begin
                        r_res.status <= imhtq_pkg::ST_EMPTY;
                        if (r_req.action == imhtq_pkg::ACT_EXTRACT) begin
                            r_res.out_handle <= '0;
                        end
                        r_state <= S_DONE;
                    end else if (r_req.action == imhtq_pkg::ACT_EXTRACT) begin
                        r_lch            <= r_hp_rdata;
                        r_res.out_handle <= r_hp_rdata.handle;
                        r_res.out_key    <= r_hp_rdata.key;
                        r_state          <= S_REMOVE;
                    end else if (!w_found) begin
                        r_res.status <= imhtq_pkg::ST_HANDLE;
                        r_state      <= S_DONE;
                    end else if (r_req.action == imhtq_pkg::ACT_DELETE) begin
                        r_lch         <= r_hp_rdata;
                        r_res.out_key <= r_hp_rdata.key;
                        r_state       <= S_REMOVE;
                    end else begin
                        // Delay: wrap the key and sift down only.
                        r_ent         <= '{key: w_dkey, handle: r_hp_rdata.handle};
                        r_res.out_key <= w_dkey;
                        r_state       <= S_DN;
                    end
                end
                S_REMOVE: begin
                    r_count           <= r_count - 1'b1;
                    r_res.entry_total <= CW'(r_count - 1'b1);
                    r_state           <= S_REMOVEW;
                end
                S_REMOVEW: begin
                    // The last entry fills the hole unless it was the one removed.
                    if (r_pos == r_count + 1'b1) begin
                        r_state <= S_DONE;
                    end else begin
                        r_ent   <= r_hp_rdata;
                        r_start <= r_pos;
                        r_dn    <= 1'b1;
                        r_state <= S_UP;
                    end
                end
                S_UP: begin
                    r_state <= (r_pos == PW'(1)) ? S_PUT : S_UPCMP;
                end
                S_UPCMP: begin
                    if (w_up_move) begin
                        r_pos   <= w_par;
                        r_state <= S_UP;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_REREAD: begin
                    r_state <= S_REREADW;
                end
                S_REREADW: begin
                    // Sift down whatever now sits where the hole was refilled.
                    r_ent   <= r_hp_rdata;
                    r_pos   <= r_start;
                    r_state <= S_DN;
                end
                S_DN: begin
                    r_state <= w_no_child ? S_PUT : S_DNL;
                end
                S_DNL: begin
                    r_lch   <= r_hp_rdata;
                    r_state <= S_DNR;
                end
                S_DNR: begin
                    // Pick the earlier child, the left one on a tie.
                    if (w_pick_right) begin
                        r_lch  <= r_hp_rdata;
                        r_cpos <= w_lc[PW-1:0] | PW'(1);
                    end else begin
                        r_cpos <= w_lc[PW-1:0];
                    end
                    r_state <= S_DNCMP;
                end
                S_DNCMP: begin
                    if (w_dn_move) begin
                        r_pos   <= r_cpos;
                        r_state <= S_DN;
                    end else begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (r_dn) begin
                        r_dn    <= 1'b0;
                        r_state <= S_REREAD;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE: begin
                    // Hold until the response register is free.
                    if (w_rsp_load) begin
                        r_rsp   <= r_res;
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid && !o_rsp.ready |=> o_rsp.valid && $stable(o_rsp.payload));

    a_no_req_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_CLEAR) |-> !i_req.ready);

    a_count_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= PW'(imhtq_pkg::HEAP_DEPTH));

    a_rsp_total: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rsp.valid |-> (o_rsp.payload.entry_total <= CW'(imhtq_pkg::HEAP_DEPTH)));

endmodule

@@ test/tb_indexed_min_heap_timer_queue.sv @@
// ----------------------------------------------------------------------------
// tb_indexed_min_heap_timer_queue
// Drives insert, extract, delete and delay transactions into the timer queue
// and checks every response against a software min-heap kept in step.
// ----------------------------------------------------------------------------
module tb_indexed_min_heap_timer_queue;

    localparam int KW = imhtq_pkg::KEY_WIDTH;
    localparam int HW = imhtq_pkg::HANDLE_W;
    localparam int CW = imhtq_pkg::COUNT_W;
    localparam int DEPTH = imhtq_pkg::HEAP_DEPTH;
    localparam int HCOUNT = imhtq_pkg::HANDLE_COUNT;

    logic i_clk;
    logic i_rst_n;

    imhtq_req_if req_ch ();
    imhtq_rsp_if rsp_ch ();

    indexed_min_heap_timer_queue u_top (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_ch.sink),
        .o_rsp   (rsp_ch.source)
    );

    // Software heap, 1-based, with a handle-to-position table.
    logic [KW-1:0] sw_keys    [1:DEPTH];
    logic [HW-1:0] sw_handles [1:DEPTH];
    int            sw_pos     [HCOUNT];
    int            sw_count;

    imhtq_pkg::t_rsp expected_rsp_q[$];
    int   error_count;
    int   rsp_count;
    int   send_idle_pct;
    int   recv_idle_pct;
    int   status_seen[4];

    initial begin
        i_clk = 1'b0;
    end
    always #4 i_clk = ~i_clk;

    // Wrap-aware "a is strictly later than b".
    function automatic bit key_after(logic [KW-1:0] a, logic [KW-1:0] b);
        logic [KW-1:0] d;
        d = a - b;
        return (d != '0) && !d[KW-1];
    endfunction

    function automatic void heap_place(int p, logic [KW-1:0] k, logic [HW-1:0] h);
        sw_keys[p]    = k;
        sw_handles[p] = h;
        sw_pos[h]     = p;
    endfunction

    function automatic void heap_raise(int p);
        logic [KW-1:0] k;
        logic [HW-1:0] h;
        k = sw_keys[p];
        h = sw_handles[p];
        while (p > 1 && key_after(sw_keys[p >> 1], k)) begin
            heap_place(p, sw_keys[p >> 1], sw_handles[p >> 1]);
            p = p >> 1;
        end
        heap_place(p, k, h);
    endfunction

    function automatic void heap_lower(int p);
        logic [KW-1:0] k;
        logic [HW-1:0] h;
        int            c;
        k = sw_keys[p];
        h = sw_handles[p];
        forever begin
            c = p << 1;
            if (c > sw_count) break;
            if (c < sw_count && key_after(sw_keys[c], sw_keys[c + 1])) c++;
            if (!key_after(k, sw_keys[c])) break;
            heap_place(p, sw_keys[c], sw_handles[c]);
            p = c;
        end
        heap_place(p, k, h);
    endfunction

    function automatic void heap_remove(int p);
        int last;
        last = sw_count;
        sw_pos[sw_handles[p]] = 0;
        sw_count--;
        if (p != last) begin
            heap_place(p, sw_keys[last], sw_handles[last]);
            heap_raise(p);
            heap_lower(p);
        end
    endfunction

    function automatic int heap_find(logic [HW-1:0] h);
        int p;
        p = sw_pos[h];
        if (p == 0 || p > sw_count || sw_handles[p] != h) return 0;
        return p;
    endfunction

    // Apply one request to the software heap and return the response it must give.
    function automatic imhtq_pkg::t_rsp predict_queue_rsp(imhtq_pkg::t_req r);
        imhtq_pkg::t_rsp    o;
        imhtq_pkg::t_action act;
        int                 p;
        act           = imhtq_pkg::t_action'(r.action);
        o.status      = imhtq_pkg::ST_OK;
        o.out_handle  = r.handle;
        o.out_key     = '0;
        if (act == imhtq_pkg::ACT_INSERT) begin
            if (sw_count >= DEPTH) begin
                o.status = imhtq_pkg::ST_FULL;
            end else if (heap_find(r.handle) != 0) begin
                o.status = imhtq_pkg::ST_HANDLE;
            end else begin
                sw_count++;
                heap_place(sw_count, r.key, r.handle);
                heap_raise(sw_count);
                o.out_key = r.key;
            end
        end else if (sw_count == 0) begin
            o.status = imhtq_pkg::ST_EMPTY;
            if (act == imhtq_pkg::ACT_EXTRACT) o.out_handle = '0;
        end else if (act == imhtq_pkg::ACT_EXTRACT) begin
            o.out_handle = sw_handles[1];
            o.out_key    = sw_keys[1];
            heap_remove(1);
        end else begin
            p = heap_find(r.handle);
            if (p == 0) begin
                o.status = imhtq_pkg::ST_HANDLE;
            end else if (act == imhtq_pkg::ACT_DELETE) begin
                o.out_key = sw_keys[p];
                heap_remove(p);
            end else begin
                sw_keys[p] = sw_keys[p] + r.key;
                o.out_key  = sw_keys[p];
                heap_lower(p);
            end
        end
        o.entry_total = CW'(sw_count);
        return o;
    endfunction

    // Send one transaction; hold valid across back-to-back items.
    task automatic send_req(imhtq_pkg::t_action act, logic [31:0] k, logic [HW-1:0] h);
        imhtq_pkg::t_req r;
        r.action = act;
        r.key    = k;
        r.handle = h;
        while ($urandom_range(99, 0) < send_idle_pct) begin
            req_ch.valid <= 1'b0;
            @(posedge i_clk);
        end
        req_ch.valid   <= 1'b1;
        req_ch.payload <= r;
        @(posedge i_clk);
        while (!req_ch.ready) @(posedge i_clk);
        expected_rsp_q.push_back(predict_queue_rsp(r));
        status_seen[int'(expected_rsp_q[$].status)]++;
    endtask

    task automatic drop_valid();
        req_ch.valid <= 1'b0;
    endtask

    task automatic drain_queue();
        drop_valid();
        while (expected_rsp_q.size() != 0) @(posedge i_clk);
        repeat (50) @(posedge i_clk);
    endtask

    // Pick a handle that is present, when any is.
    function automatic logic [HW-1:0] live_handle();
        if (sw_count == 0) return HW'($urandom_range(HCOUNT - 1, 0));
        return sw_handles[$urandom_range(sw_count, 1)];
    endfunction

    // Receiver: random backpressure, then check each accepted response.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rsp_ch.ready <= 1'b0;
        end else begin
            if (rsp_ch.valid && rsp_ch.ready) begin
                rsp_count++;
                if (expected_rsp_q.size() == 0) begin
                    $error("unexpected response %p", rsp_ch.payload);
                    error_count++;
                end else begin
                    imhtq_pkg::t_rsp e;
                    e = expected_rsp_q.pop_front();
                    if (rsp_ch.payload.status !== e.status) begin
                        $error("status exp %0d got %0d", e.status, rsp_ch.payload.status);
                        error_count++;
                    end
                    if (rsp_ch.payload.out_handle !== e.out_handle) begin
                        $error("out_handle exp %0d got %0d", e.out_handle,
                               rsp_ch.payload.out_handle);
                        error_count++;
                    end
                    if (rsp_ch.payload.out_key !== e.out_key) begin
                        $error("out_key exp %0h got %0h", e.out_key, rsp_ch.payload.out_key);
                        error_count++;
                    end
                    if (rsp_ch.payload.entry_total !== e.entry_total) begin
                        $error("entry_total exp %0d got %0d", e.entry_total,
                               rsp_ch.payload.entry_total);
                        error_count++;
                    end
                end
            end
            rsp_ch.ready <= ($urandom_range(99, 0) >= recv_idle_pct);
        end
    end

    // Empty-heap errors, extremes of key and handle, every action.
    task automatic test_directed();
        send_req(imhtq_pkg::ACT_EXTRACT, 32'h0, 11'd5);
        send_req(imhtq_pkg::ACT_DELETE, 32'h0, 11'd5);
        send_req(imhtq_pkg::ACT_DELAY, 32'h1, 11'd5);
        send_req(imhtq_pkg::ACT_INSERT, 32'hFFFF_FFFF, 11'd2047);
        send_req(imhtq_pkg::ACT_INSERT, 32'h0, 11'd0);
        send_req(imhtq_pkg::ACT_INSERT, 32'h8000_0000, 11'd1024);
        send_req(imhtq_pkg::ACT_INSERT, 32'h7FFF_FFFF, 11'd1023);
        send_req(imhtq_pkg::ACT_INSERT, 32'h0, 11'd0);
        send_req(imhtq_pkg::ACT_INSERT, 32'h10, 11'd1);
        send_req(imhtq_pkg::ACT_INSERT, 32'h10, 11'd2);
        send_req(imhtq_pkg::ACT_DELETE, 32'h0, 11'd77);
        send_req(imhtq_pkg::ACT_DELAY, 32'h5, 11'd77);
        send_req(imhtq_pkg::ACT_DELAY, 32'hFFFF_FFFF, 11'd2047);
        send_req(imhtq_pkg::ACT_DELAY, 32'h7FFF_FFFF, 11'd0);
        send_req(imhtq_pkg::ACT_DELETE, 32'h0, 11'd1024);
        send_req(imhtq_pkg::ACT_DELETE, 32'h0, 11'd2);
        repeat (6) send_req(imhtq_pkg::ACT_EXTRACT, 32'h0, 11'h7FF);
        send_req(imhtq_pkg::ACT_EXTRACT, 32'h0, 11'd0);
        drain_queue();
    endtask

    // Fill to full (status full), then act on the full heap.
    task automatic test_full_heap();
        for (int i = 0; i < DEPTH; i++)
            send_req(imhtq_pkg::ACT_INSERT, $urandom, HW'(i * 2 + 1));
        send_req(imhtq_pkg::ACT_INSERT, 32'h1, 11'd0);
        send_req(imhtq_pkg::ACT_DELAY, $urandom, 11'd1);
        send_req(imhtq_pkg::ACT_DELETE, 32'h0, 11'd2047);
        repeat (5) send_req(imhtq_pkg::ACT_EXTRACT, 32'h0, 11'd0);
        drain_queue();
    endtask

    // Random mix biased toward live handles and close keys.
    task automatic test_random(int n);
        imhtq_pkg::t_action act;
        logic [31:0] k;
        logic [HW-1:0] h;
        for (int i = 0; i < n; i++) begin
            act = imhtq_pkg::t_action'($urandom_range(3, 0));
            if ($urandom_range(2, 0) == 0) act = imhtq_pkg::ACT_INSERT;
            k = ($urandom_range(3, 0) == 0) ? $urandom : 32'($urandom_range(300, 0));
            h = ($urandom_range(4, 0) != 0 && act != imhtq_pkg::ACT_INSERT) ? live_handle()
                : HW'($urandom_range(HCOUNT - 1, 0));
            send_req(act, k, h);
        end
        drain_queue();
    endtask

    initial begin
        #20_000_000;
        $display("CHECKS FAILED");
        $finish;
    end

    initial begin
        error_count   = 0;
        rsp_count     = 0;
        sw_count      = 0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        foreach (sw_pos[i]) sw_pos[i] = 0;
        foreach (status_seen[i]) status_seen[i] = 0;
        i_rst_n        = 1'b0;
        req_ch.valid   = 1'b0;
        req_ch.payload = '0;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        send_idle_pct = 27; recv_idle_pct = 81;
        test_directed();
        test_random(40);
        send_idle_pct = 81; recv_idle_pct = 27;
        test_random(40);
        send_idle_pct = 0;  recv_idle_pct = 0;
        test_full_heap();
        test_random(40);

        $display("Covered %0d responses: ok %0d, empty %0d, full %0d, bad handle %0d",
                 rsp_count, status_seen[0], status_seen[1], status_seen[2], status_seen[3]);
        $display("Ran empty, full and deep-heap cases under three backpressure mixes");
        if (error_count == 0 && expected_rsp_q.size() == 0) begin
            $display("ALL CHECKS PASSED");
        end else begin
            $display("CHECKS FAILED");
        end
        $finish;
    end
endmodule

@@ filelist.f @@
rtl/imhtq_pkg.sv
rtl/imhtq_if.sv
rtl/indexed_min_heap_timer_queue.sv
test/tb_indexed_min_heap_timer_queue.sv
